/* src/swept_aabb_collision_test_top_macros.svh */
// assertion macros for the swept box collision test
`ifndef SWEPT_AABB_COLLISION_TEST_TOP_MACROS_SVH
`define SWEPT_AABB_COLLISION_TEST_TOP_MACROS_SVH

// same-cycle implication, checked on every clock outside reset
`define SACD_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sacd same-cycle check failed");

// next-cycle implication
`define SACD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sacd next-cycle check failed");

`endif

/* src/sacd_pkg.sv */
// shared types, constants and the divider step for the swept box test
package sacd_pkg;

    localparam int NUM_REGS  = 6;
    localparam int DIV_STEPS = 18;
    // input register, quotient steps, fix-up register
    localparam int DIV_LAT   = DIV_STEPS + 2;
    localparam int PIPE_LAT  = DIV_LAT + 1;

    localparam logic [2:0] REG_MIN_X = 3'd0;
    localparam logic [2:0] REG_MIN_Y = 3'd1;
    localparam logic [2:0] REG_MIN_Z = 3'd2;
    localparam logic [2:0] REG_MAX_X = 3'd3;
    localparam logic [2:0] REG_MAX_Y = 3'd4;
    localparam logic [2:0] REG_MAX_Z = 3'd5;

    localparam logic [1:0] AXIS_X    = 2'd0;
    localparam logic [1:0] AXIS_Y    = 2'd1;
    localparam logic [1:0] AXIS_Z    = 2'd2;
    localparam logic [1:0] AXIS_NONE = 2'd3;

    typedef logic signed [19:0] time_t;
    typedef logic signed [31:0] coord_t;

    localparam time_t TIME_ZERO = 20'sd0;
    localparam time_t TIME_ONE  = 20'sd65536;
    localparam time_t TIME_SAT  = 20'sd131072;
    localparam time_t TIME_INF  = 20'sd262144;

    typedef struct packed {
        logic       hit;
        logic [16:0] entry_time;
        logic [1:0]  hit_axis;
    } result_t;

    // one restoring step: {quotient bit, new remainder}
    function automatic logic [32:0] div_step(logic [31:0] rem, logic b, logic [31:0] m);
        logic [32:0] t;
        logic [32:0] d;
        t = {rem, b};
        d = t - {1'b0, m};
        if (t >= {1'b0, m})
            div_step = {1'b1, d[31:0]};
        else
            div_step = {1'b0, t[31:0]};
    endfunction

endpackage

/* src/sacd_div.sv */
// pipelined saturating divider: floor(d * 2^16 / v) clipped to the time range
module sacd_div
    import sacd_pkg::*;
(
    input  logic               clk,
    input  logic               en,
    input  logic signed [32:0] d,
    input  logic signed [31:0] v,
    output time_t              t
);

    logic [31:0]          m_reg   [0:DIV_STEPS];
    logic [31:0]          rem_reg [0:DIV_STEPS];
    logic [DIV_STEPS-1:0] low_reg [0:DIV_STEPS];
    logic [DIV_STEPS-1:0] q_reg   [0:DIV_STEPS];
    logic                 neg_reg [0:DIV_STEPS];
    logic                 sat_reg [0:DIV_STEPS];
    time_t                t_reg;

    logic [32:0] d_abs;
    logic [31:0] v_abs;
    logic [33:0] m4;
    logic [18:0] q_fix;
    logic [18:0] q_clip;
    time_t       t_next;

    always_comb
    begin
        d_abs = d[32] ? 33'(-d) : 33'(d);
        v_abs = v[31] ? 32'(-v) : 32'(v);
        m4    = {v_abs, 2'b00};
        q_fix = {1'b0, q_reg[DIV_STEPS]}
              + 19'(neg_reg[DIV_STEPS] && (rem_reg[DIV_STEPS] != 32'd0));
        if (sat_reg[DIV_STEPS] || (q_fix > 19'(TIME_SAT)))
            q_clip = 19'(TIME_SAT);
        else
            q_clip = q_fix;
        t_next = neg_reg[DIV_STEPS] ? -time_t'({1'b0, q_clip}) : time_t'({1'b0, q_clip});
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // quotient at or above 2^18 is saturated anyway
            m_reg[0]   <= v_abs;
            rem_reg[0] <= 32'(d_abs >> 2);
            low_reg[0] <= {d_abs[1:0], 16'd0};
            q_reg[0]   <= '0;
            neg_reg[0] <= (d != 33'sd0) && (d[32] != v[31]);
            sat_reg[0] <= {1'b0, d_abs} >= m4;
            for (int i = 0; i < DIV_STEPS; i++)
            begin
                logic [32:0] s;
                s = div_step(rem_reg[i], low_reg[i][DIV_STEPS-1], m_reg[i]);
                m_reg[i+1]   <= m_reg[i];
                rem_reg[i+1] <= s[31:0];
                low_reg[i+1] <= {low_reg[i][DIV_STEPS-2:0], 1'b0};
                q_reg[i+1]   <= {q_reg[i][DIV_STEPS-2:0], s[32]};
                neg_reg[i+1] <= neg_reg[i];
                sat_reg[i+1] <= sat_reg[i];
            end
            t_reg <= t_next;
        end
    end

    assign t = t_reg;

endmodule

/* src/sacd_lane.sv */
// one axis lane: hull overlap, entry and exit distances, two dividers
module sacd_lane
    import sacd_pkg::*;
(
    input  logic   clk,
    input  logic   en,
    input  coord_t v,
    input  coord_t omin,
    input  coord_t omax,
    input  coord_t mmin,
    input  coord_t mmax,
    output time_t  entry_t,
    output time_t  exit_t,
    output logic   ovl
);

    logic signed [32:0] v_w, omin_w, omax_w, mmin_w, mmax_w;
    logic signed [32:0] hmin, hmax, de, dx;
    logic               ovl_c;
    logic               zero_c;
    time_t              div_entry, div_exit;
    logic [DIV_LAT-1:0] ovl_reg;
    logic [DIV_LAT-1:0] zero_reg;

    always_comb
    begin
        v_w    = 33'(v);
        omin_w = 33'(omin);
        omax_w = 33'(omax);
        mmin_w = 33'(mmin);
        mmax_w = 33'(mmax);
        hmin   = v[31] ? mmin_w + v_w : mmin_w;
        hmax   = (!v[31] && v != 32'sd0) ? mmax_w + v_w : mmax_w;
        ovl_c  = (hmin <= omax_w) && (hmax >= omin_w);
        zero_c = (v == 32'sd0);
        if (!v[31] && !zero_c)
        begin
            de = omin_w - mmax_w;
            dx = omax_w - mmin_w;
        end
        else
        begin
            de = omax_w - mmin_w;
            dx = omin_w - mmax_w;
        end
    end

    sacd_div u_div_entry (.clk(clk), .en(en), .d(de), .v(v), .t(div_entry));
    sacd_div u_div_exit  (.clk(clk), .en(en), .d(dx), .v(v), .t(div_exit));

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ovl_reg  <= {ovl_reg[DIV_LAT-2:0], ovl_c};
            zero_reg <= {zero_reg[DIV_LAT-2:0], zero_c};
        end
    end

    // a still axis never bounds the interval
    assign entry_t = zero_reg[DIV_LAT-1] ? -TIME_INF : div_entry;
    assign exit_t  = zero_reg[DIV_LAT-1] ? TIME_INF : div_exit;
    assign ovl     = ovl_reg[DIV_LAT-1];

endmodule

/* src/sacd_merge.sv */
// merges the three lanes: latest entry, earliest exit, hit decision and axis
module sacd_merge
    import sacd_pkg::*;
(
    input  logic    clk,
    input  logic    en,
    input  time_t   entry_t [3],
    input  time_t   exit_t  [3],
    input  logic    ovl     [3],
    output result_t res
);

    time_t   ent, ext;
    result_t res_next;
    result_t res_reg;

    always_comb
    begin
        ent = entry_t[0];
        ext = exit_t[0];
        for (int a = 1; a < 3; a++)
        begin
            if (entry_t[a] > ent)
                ent = entry_t[a];
            if (exit_t[a] < ext)
                ext = exit_t[a];
        end
        res_next.hit        = 1'b0;
        res_next.entry_time = 17'(TIME_ONE);
        res_next.hit_axis   = AXIS_NONE;
        if (ovl[0] && ovl[1] && ovl[2] && !(ent > ext) && !(ent < TIME_ZERO)
            && !(ent > TIME_ONE))
        begin
            res_next.hit        = 1'b1;
            res_next.entry_time = ent[16:0];
            // ties go to x, then y
            priority if (ent == entry_t[0])
                res_next.hit_axis = AXIS_X;
            else if (ent == entry_t[1])
                res_next.hit_axis = AXIS_Y;
            else
                res_next.hit_axis = AXIS_Z;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
            res_reg <= res_next;
    end

    assign res = res_reg;

endmodule

/* src/swept_aabb_collision_test_top.sv */
// top level of the swept box collision test: config, lanes, merge and output skid
//
//  channel   dir  width  contents
//  s_axis    in   288    vel xyz, obstacle min xyz, obstacle max xyz
//  m_axis    out  24+1   tdata entry_time, hit_axis; tuser hit
//  cfg       in   32     mover min xyz, max xyz at indexes 0..5
//
// one item enters per clock while the skid register is empty; a result passes
// the input register, 18-step divider and fix-up register of each lane, then
// the merge and output registers. no clearing pass after reset. an output
// register and a skid register let one more item in while a result waits; after
// that the whole pipeline holds until the result is taken
module swept_aabb_collision_test_top
    import sacd_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [287:0] s_tdata,   // vel_x, vel_y, vel_z, obstacle_min_x/y/z, obstacle_max_x/y/z
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [23:0]  m_tdata,   // entry_time[16:0], hit_axis[18:17], zero fill
    output logic         m_tuser,   // hit
    input  logic         cfg_we,
    input  logic [2:0]   cfg_addr,
    input  logic [31:0]  cfg_wdata
);

    coord_t              mover_reg [NUM_REGS];
    logic [PIPE_LAT-1:0] vld_reg;
    logic                en;
    time_t               entry_t [3];
    time_t               exit_t  [3];
    logic                ovl     [3];
    result_t             p_res;
    logic                p_valid;
    result_t             out_reg, skid_reg;
    logic                out_valid_reg, skid_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mover_reg[REG_MIN_X] <= 32'sd0;
            mover_reg[REG_MIN_Y] <= 32'sd0;
            mover_reg[REG_MIN_Z] <= 32'sd0;
            mover_reg[REG_MAX_X] <= 32'sd65536;
            mover_reg[REG_MAX_Y] <= 32'sd65536;
            mover_reg[REG_MAX_Z] <= 32'sd65536;
        end
        else if (cfg_we && (cfg_addr <= REG_MAX_Z))
            mover_reg[cfg_addr] <= cfg_wdata;
    end

    assign en       = !skid_valid_reg;
    assign s_tready = en;

    genvar a;
    generate
        for (a = 0; a < 3; a++)
        begin : g_lane
            sacd_lane u_lane (
                .clk    (clk),
                .en     (en),
                .v      (s_tdata[32*a +: 32]),
                .omin   (s_tdata[32*(a+3) +: 32]),
                .omax   (s_tdata[32*(a+6) +: 32]),
                .mmin   (mover_reg[a]),
                .mmax   (mover_reg[a+3]),
                .entry_t(entry_t[a]),
                .exit_t (exit_t[a]),
                .ovl    (ovl[a])
            );
        end
    endgenerate

    sacd_merge u_merge (
        .clk    (clk),
        .en     (en),
        .entry_t(entry_t),
        .exit_t (exit_t),
        .ovl    (ovl),
        .res    (p_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[PIPE_LAT-2:0], s_tvalid};
    end

    assign p_valid = vld_reg[PIPE_LAT-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || m_tready)
        begin
            out_valid_reg  <= skid_valid_reg || (en && p_valid);
            skid_valid_reg <= 1'b0;
        end
        else if (en && p_valid)
            skid_valid_reg <= 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || m_tready)
            out_reg <= skid_valid_reg ? skid_reg : p_res;
        else if (en && p_valid)
            skid_reg <= p_res;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.hit;
    assign m_tdata  = {5'd0, out_reg.hit_axis, out_reg.entry_time};

`include "swept_aabb_collision_test_top_macros.svh"

    `SACD_ASSERT_IMPL(a_skid_behind_out, skid_valid_reg, out_valid_reg)
    `SACD_ASSERT_IMPL(a_hit_has_axis, m_tvalid && m_tuser, m_tdata[18:17] != AXIS_NONE)
    `SACD_ASSERT_IMPL(a_miss_fields, m_tvalid && !m_tuser,
                      m_tdata[18:17] == AXIS_NONE && m_tdata[16:0] == 17'(TIME_ONE))
    `SACD_ASSERT_NEXT(a_skid_fill, out_valid_reg && !m_tready && en && p_valid, skid_valid_reg)

endmodule
